### sv/stable_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, codes and word types shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH    = 16;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int PRIO_W   = 4;
	localparam int HANDLE_W = 8;
	localparam int OCC_W    = 5;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t data;
	} cmd_t;

endpackage

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted row: keeps, takes the new word, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic           clk,
	input  spq_pkg::cmd_t  cmd,
	input  logic           occupied,
	input  logic           left_ge,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	output spq_pkg::entry_t entry,
	output logic           ge
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	assign ge    = occupied && (entry_q.prio >= cmd.data.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (cmd.enq) begin
			// hold behind equal or higher priority, else insert or shift down
			priority if (ge) begin
				entry_d = entry_q;
			end else if (left_ge) begin
				entry_d = cmd.data;
			end else begin
				entry_d = left_entry;
			end
		end else if (cmd.deq) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### sv/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Stable priority queue core
// Sorted row of cells holding process handles by priority, FIFO among ties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: action
//   selects enqueue of process_handle at priority_req, or dequeue of the
//   front entry. Output channel (out_valid / out_stall) returns one result
//   word per request: status, the removed handle and priority on a good
//   dequeue (else zero), and the occupancy after the request.
//   The result word is registered at the edge that
//   accepts the request. Throughput is one request per cycle when not stalled; the sorted
//   insert or front removal happens in the cell row in that same cycle,
//   each cell choosing between hold, new word and its neighbor.
//   When the receiver stalls, the result word holds and in_stall rises, so
//   no new request is taken until the result drains.
//   Reset clears the entry count and the output valid; slot contents need
//   no clearing since only occupied cells are compared or read.
// ----------------------------------------------------------------------------
module stable_priority_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [spq_pkg::HANDLE_W-1:0]  process_handle,
	input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [spq_pkg::HANDLE_W-1:0]  out_handle,
	output logic [spq_pkg::PRIO_W-1:0]    out_priority,
	output logic [spq_pkg::OCC_W-1:0]     occupancy
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int CNT_W = spq_pkg::CNT_W;
	localparam int OCC_W = spq_pkg::OCC_W;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic                   out_valid_q;
	spq_pkg::status_t       status_q;
	spq_pkg::status_t       status_d;
	spq_pkg::entry_t        result_q;
	spq_pkg::entry_t        result_d;
	logic [OCC_W-1:0]       occ_q;
	logic [CNT_W+OCC_W-1:0] occ_wide;

	logic                   fire;
	logic                   full;
	logic                   empty;
	spq_pkg::cmd_t          cmd;

	spq_pkg::entry_t        cell_entry [DEPTH];
	logic                   cell_ge    [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		cmd.enq         = fire && (action == spq_pkg::ACT_ENQ) && !full;
		cmd.deq         = fire && (action == spq_pkg::ACT_DEQ) && !empty;
		cmd.data.prio   = priority_req;
		cmd.data.handle = process_handle;
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic            occupied;
			logic            left_ge;
			spq_pkg::entry_t left_entry;
			spq_pkg::entry_t right_entry;

			assign occupied = (CNT_W'(i) < count_q);

			if (i == 0) begin : g_head
				assign left_ge    = 1'b1;
				assign left_entry = cell_entry[i];
			end else begin : g_body
				assign left_ge    = cell_ge[i-1];
				assign left_entry = cell_entry[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign right_entry = cell_entry[i];
			end else begin : g_inner
				assign right_entry = cell_entry[i+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occupied),
				.left_ge     (left_ge),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		status_d = spq_pkg::STATUS_DONE;
		result_d = '0;
		unique case (action)
			spq_pkg::ACT_ENQ: begin
				if (full) begin
					status_d = spq_pkg::STATUS_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			spq_pkg::ACT_DEQ: begin
				if (empty) begin
					status_d = spq_pkg::STATUS_EMPTY;
				end else begin
					count_d  = count_q - CNT_W'(1);
					result_d = cell_entry[0];
				end
			end
			default: begin
				status_d = spq_pkg::STATUS_DONE;
			end
		endcase
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			result_q <= result_d;
			occ_q    <= occ_wide[OCC_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_handle   = result_q.handle;
	assign out_priority = result_q.prio;
	assign occupancy    = occ_q;

endmodule

### sv/spq_checker.sv
// ----------------------------------------------------------------------------
// Stable priority queue port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_core_macros.svh"

module spq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         action,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [spq_pkg::HANDLE_W-1:0] out_handle,
	input logic [spq_pkg::PRIO_W-1:0]   out_priority,
	input logic [spq_pkg::OCC_W-1:0]    occupancy
);

	`SPQ_ASSERT_IMPL(a_empty_result, out_valid && (status == spq_pkg::STATUS_EMPTY), (occupancy == '0) && (out_handle == '0) && (out_priority == '0), "empty dequeue word not cleared")
	`SPQ_ASSERT_IMPL(a_full_result, out_valid && (status == spq_pkg::STATUS_FULL), (occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)) && (out_handle == '0) && (out_priority == '0), "full enqueue word inconsistent")
	`SPQ_ASSERT_NEXT(a_deq_result, in_valid && !in_stall && (action == spq_pkg::ACT_DEQ), out_valid && (status != spq_pkg::STATUS_FULL), "dequeue produced no word or a full status")
	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_handle) && $stable(out_priority) && $stable(occupancy), "stalled result word changed")

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (.*);
